@@ rtl/wae_pkg.sv @@
// ----------------------------------------------------------------------------
// wae_pkg
// shared types and constants of the walkable area erosion block
// ----------------------------------------------------------------------------
package wae_pkg;

   // grid size and map geometry defaults
   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;
   localparam int MAX_RADIUS_DEF = 15;

   // signed width of a probed window coordinate: 0..255 plus or minus the radius
   localparam int CW = 11;

   // register widths
   localparam int SIZE_W   = 9;
   localparam int RADIUS_W = 4;

   // area codes
   localparam logic [7:0] AREA_WALKABLE = 8'd1;
   localparam logic [7:0] AREA_OBSTACLE = 8'd2;

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_CLASSIFY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_GRID_WIDTH   = 2'd0,
      CSR_GRID_HEIGHT  = 2'd1,
      CSR_ERODE_RADIUS = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

@@ rtl/wae_ram.sv @@
// ----------------------------------------------------------------------------
// wae_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wae_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/walkable_area_erosion_top.sv @@
// ----------------------------------------------------------------------------
// walkable_area_erosion_top
// square window erosion of walkable spans over a one-bit occupancy map
// ----------------------------------------------------------------------------
// The block keeps one occupancy bit per grid cell in a ram. A load beat
// (tuser op = 0) writes one cell's bit into the map and returns nothing;
// loads outside the grid are dropped. A classify beat (op = 1) returns one
// result beat: a walkable span (area 1) turns into obstacle (area 2) when any
// cell of the square window of radius erode_radius around it, the centre left
// out, is outside the grid or empty. Non-walkable spans, radius zero and cells
// outside the grid skip the window scan and come back unchanged. A walkable span
// walks the window row by row through the single map read port, one probe per
// cycle, and stops at the first empty or outside cell. The input is held
// off while a classify beat is in work, also while its result waits for the
// previous result to leave the output register; a finished result sits in
// the output register so the next beat can be taken while it waits. Every
// cell must be loaded before it is probed.
// The user must write configuration only while the block is idle; the block
// itself does not enforce it. The grid in use is min(grid_width, MAX_WIDTH)
// by min(grid_height, MAX_HEIGHT) and the radius saturates at MAX_RADIUS.
// ----------------------------------------------------------------------------
module walkable_area_erosion_top #(
   parameter int MAX_WIDTH  = wae_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = wae_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = wae_pkg::MAX_RADIUS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // cell_x[7:0], cell_y[15:8], occupied[16], span_area[24:17]
   input  logic [0:0]  req_tuser,  // op[0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // new_area[7:0], at_border[8]
   // configuration writes
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [8:0]  csr_wdata
);

   localparam int CW    = wae_pkg::CW;
   localparam int RW    = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WCAP  = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
   localparam int HCAP  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

   // configuration registers
   logic [8:0] grid_width_ff;
   logic [8:0] grid_height_ff;
   logic [3:0] erode_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= 9'd256;
         grid_height_ff  <= 9'd256;
         erode_radius_ff <= 4'd0;
      end else if (csr_we) begin
         unique case (wae_pkg::csr_idx_type'(csr_addr))
            wae_pkg::CSR_GRID_WIDTH:   grid_width_ff   <= csr_wdata;
            wae_pkg::CSR_GRID_HEIGHT:  grid_height_ff  <= csr_wdata;
            wae_pkg::CSR_ERODE_RADIUS: erode_radius_ff <= csr_wdata[3:0];
            default: ;  // index beyond the register list is dropped
         endcase
      end
   end

   // grid in use and saturated radius
   logic [8:0]    w_used;
   logic [8:0]    h_used;
   logic [RW-1:0] r_sat;

   assign w_used = (int'(grid_width_ff)  < WCAP) ? grid_width_ff  : 9'(WCAP);
   assign h_used = (int'(grid_height_ff) < HCAP) ? grid_height_ff : 9'(HCAP);
   assign r_sat  = RW'((int'(erode_radius_ff) < MAX_RADIUS) ? int'(erode_radius_ff)
                                                            : MAX_RADIUS);

   // request fields
   wae_pkg::op_type req_op;
   logic [7:0]      req_x;
   logic [7:0]      req_y;
   logic            req_occ;
   logic [7:0]      req_area;
   logic            req_in_grid;

   assign req_op      = wae_pkg::op_type'(req_tuser[0]);
   assign req_x       = req_tdata[7:0];
   assign req_y       = req_tdata[15:8];
   assign req_occ     = req_tdata[16];
   assign req_area    = req_tdata[24:17];
   assign req_in_grid = ({1'b0, req_x} < w_used) && ({1'b0, req_y} < h_used);

   // sequencer state
   wae_pkg::state_type state_ff, state_in;
   logic [7:0]    cx_ff, cx_in;
   logic [7:0]    cy_ff, cy_in;
   logic [7:0]    area_ff, area_in;
   logic [RW-1:0] r_ff, r_in;
   logic [RW:0]   dx_ff, dx_in;      // signed window offset
   logic [RW:0]   dy_ff, dy_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          border_ff, border_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_area_ff, rsp_area_in;
   logic          rsp_border_ff, rsp_border_in;

   // map ram ports
   logic          mem_we;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic          mem_rd_data;

   // window probe address generation
   logic [CW-1:0] nx;
   logic [CW-1:0] ny;
   logic [RW:0]   r_pos;
   logic          probe_out;
   logic          probe_center;
   logic          probe_last;
   logic          probe_empty;

   assign r_pos        = {1'b0, r_ff};
   assign nx           = {{(CW-8){1'b0}}, cx_ff} + {{(CW-RW-1){dx_ff[RW]}}, dx_ff};
   assign ny           = {{(CW-8){1'b0}}, cy_ff} + {{(CW-RW-1){dy_ff[RW]}}, dy_ff};
   assign probe_out    = nx[CW-1] || ny[CW-1]
                      || (nx >= {{(CW-9){1'b0}}, w_used})
                      || (ny >= {{(CW-9){1'b0}}, h_used});
   assign probe_center = (dx_ff == '0) && (dy_ff == '0);
   assign probe_last   = (dx_ff == r_pos) && (dy_ff == r_pos);
   assign probe_empty  = rd_pend_ff && !mem_rd_data;  // previous probe found an empty cell

   assign mem_rd_addr = AW'(32'(ny) * 32'(MAX_WIDTH) + 32'(nx));
   assign mem_wr_addr = AW'(32'(req_y) * 32'(MAX_WIDTH) + 32'(req_x));

   assign req_tready = (state_ff == wae_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      area_in       = area_ff;
      r_in          = r_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      rd_pend_in    = 1'b0;
      border_in     = border_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_area_in   = rsp_area_ff;
      rsp_border_in = rsp_border_ff;
      mem_we        = 1'b0;
      mem_rd_en     = 1'b0;

      // result beat leaves
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wae_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == wae_pkg::OP_LOAD) begin
                  mem_we = req_in_grid;
               end else begin
                  cx_in     = req_x;
                  cy_in     = req_y;
                  area_in   = req_area;
                  r_in      = r_sat;
                  dx_in     = -{1'b0, r_sat};
                  dy_in     = -{1'b0, r_sat};
                  border_in = 1'b0;
                  if (req_in_grid && (r_sat != '0) && (req_area == wae_pkg::AREA_WALKABLE)) begin
                     state_in = wae_pkg::ST_SCAN;
                  end else begin
                     state_in = wae_pkg::ST_DONE;
                  end
               end
            end
         end
         wae_pkg::ST_SCAN: begin
            if (probe_out || probe_empty) begin
               border_in = 1'b1;
               state_in  = wae_pkg::ST_DONE;
            end else begin
               mem_rd_en  = !probe_center;
               rd_pend_in = !probe_center;
               if (probe_last) begin
                  state_in = wae_pkg::ST_DRAIN;
               end else if (dx_ff == r_pos) begin
                  dx_in = -r_pos;
                  dy_in = dy_ff + 1'b1;
               end else begin
                  dx_in = dx_ff + 1'b1;
               end
            end
         end
         wae_pkg::ST_DRAIN: begin
            // last probe's data is back now
            if (probe_empty) begin
               border_in = 1'b1;
            end
            state_in = wae_pkg::ST_DONE;
         end
         wae_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_area_in   = border_ff ? wae_pkg::AREA_OBSTACLE : area_ff;
               rsp_border_in = border_ff;
               state_in      = wae_pkg::ST_IDLE;
            end
         end
         default: state_in = wae_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wae_pkg::ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      area_ff       <= area_in;
      r_ff          <= r_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      border_ff     <= border_in;
      rsp_area_ff   <= rsp_area_in;
      rsp_border_ff <= rsp_border_in;
   end

   // occupancy map
   wae_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (req_occ),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_border_ff, rsp_area_ff};

`ifndef SYNTH
   // a border result always reports an obstacle
   a_border_area: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:0] == wae_pkg::AREA_OBSTACLE)
      else $error("border result without obstacle area");

   // the map is written only by a load beat while idle
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == wae_pkg::ST_IDLE && req_tvalid
                 && req_op == wae_pkg::OP_LOAD)
      else $error("map write outside a load beat");

   // a pending map read was issued by the window scan
   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff) == wae_pkg::ST_SCAN)
      else $error("map read pending without a scan");

   // a classify beat never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("waiting result dropped");
`endif

endmodule
